[rtl/lzbf_pkg.sv]
`timescale 1ns / 1ps
package lzbf_pkg;

   localparam int WindowBytesDefault = 65536;
   localparam int DistWidth = 24;
   localparam int CopyWidth = 17;
   localparam logic [DistWidth-1:0] LongDistance = 24'h000d00;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusBadDistance = 2'd1;
   localparam logic [1:0] StatusBadKind = 2'd2;

   localparam logic CmdByte = 1'b0;
   localparam logic CmdContinue = 1'b1;

   typedef enum logic [3:0] {
      PH_FLAG,
      PH_DA,
      PH_DB,
      PH_LIT,
      PH_DBYTE,
      PH_LA,
      PH_LB,
      PH_XA,
      PH_XB,
      PH_COPY,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PARSE,
      ST_CHECK,
      ST_READ,
      ST_WAIT,
      ST_SEND
   } ctrl_type;

endpackage

[rtl/lz_bitflag_decompressor.sv]
`timescale 1ns / 1ps
// One item is taken at a time: each item is accepted in the idle state and then
// holds its result in an output register until it is taken, so an item with no
// further work goes straight to that register. A byte that completes a flag word, a
// literal, a distance byte and the last continue of a match then parse buffered flag
// bits one flag or gamma bit at a time (up to sixteen) before the result is sent;
// each match start adds a check state for the distance check. A continue item adds
// the read and wait states for the registered read of the history memory.
module lz_bitflag_decompressor #(
   parameter int WINDOW_BYTES = lzbf_pkg::WindowBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte, copy_pending, finished, status, zero fill
   output logic        rsp_tuser    // out_valid
);

   localparam int AddrWidth = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
   localparam int CountWidth = $clog2(WINDOW_BYTES + 1);

   lzbf_pkg::ctrl_type ctrl_ff, ctrl_in;
   lzbf_pkg::phase_type phase_ff, phase_in;
   logic [7:0] history [WINDOW_BYTES];
   logic [AddrWidth-1:0] write_pos_ff, write_pos_in, rd_addr_ff, rd_addr_in;
   logic [CountWidth-1:0] produced_ff, produced_in;
   logic [15:0] bit_word_ff, bit_word_in, acc_ff, acc_in;
   logic [4:0] bits_left_ff, bits_left_in;
   logic [7:0] low_half_ff, low_half_in, rd_data_ff, out_byte_ff, out_byte_in;
   logic low_held_ff, low_held_in;
   logic [lzbf_pkg::DistWidth-1:0] dist_ff, dist_in;
   logic [lzbf_pkg::CopyWidth-1:0] copy_left_ff, copy_left_in;
   logic [1:0] err_ff, err_in;
   logic done_ff, done_in, out_valid_ff, out_valid_in;
   logic wr_en;
   logic [7:0] wr_data;
   logic bit_now;
   logic [16:0] acc_shift;
   logic [lzbf_pkg::CopyWidth-1:0] len_calc;
   logic [AddrWidth:0] idx_wide;
   logic req_fire, rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign req_tready = (ctrl_ff == lzbf_pkg::ST_IDLE);
   assign rsp_tvalid = (ctrl_ff == lzbf_pkg::ST_SEND);
   assign rsp_tuser = out_valid_ff;
   assign rsp_tdata = {4'd0, err_ff, done_ff,
                       (err_ff == lzbf_pkg::StatusOk) && (phase_ff == lzbf_pkg::PH_COPY),
                       out_byte_ff};

   assign bit_now = bit_word_ff[bits_left_ff[3:0] - 4'd1];
   assign acc_shift = {acc_ff, bit_now};
   assign len_calc = lzbf_pkg::CopyWidth'(acc_ff) + 17'd1 +
                     ((phase_ff == lzbf_pkg::PH_XB) ? 17'd2 : 17'd0) +
                     ((dist_ff > lzbf_pkg::LongDistance) ? 17'd1 : 17'd0);

   always_comb begin
      if ({{(AddrWidth + 1 - 1){1'b0}}, 1'b0} + (AddrWidth + 1)'(write_pos_ff)
          >= (AddrWidth + 1)'(dist_ff)) begin
         idx_wide = (AddrWidth + 1)'(write_pos_ff) - (AddrWidth + 1)'(dist_ff);
      end else begin
         idx_wide = (AddrWidth + 1)'(write_pos_ff) + (AddrWidth + 1)'(WINDOW_BYTES)
                    - (AddrWidth + 1)'(dist_ff);
      end
   end

   always_comb begin
      ctrl_in = ctrl_ff;
      unique case (ctrl_ff)
         lzbf_pkg::ST_IDLE: begin
            if (req_fire) begin
               ctrl_in = lzbf_pkg::ST_SEND;
               if (err_ff == lzbf_pkg::StatusOk && !done_ff) begin
                  if (req_tuser == lzbf_pkg::CmdContinue) begin
                     if (phase_ff == lzbf_pkg::PH_COPY) begin
                        ctrl_in = lzbf_pkg::ST_READ;
                     end
                  end else if (phase_ff != lzbf_pkg::PH_COPY) begin
                     if (phase_ff == lzbf_pkg::PH_LIT || phase_ff == lzbf_pkg::PH_DBYTE
                         || low_held_ff) begin
                        ctrl_in = lzbf_pkg::ST_PARSE;
                     end
                  end
               end
            end
         end
         lzbf_pkg::ST_PARSE: begin
            if (err_ff != lzbf_pkg::StatusOk || bits_left_ff == 5'd0
                || phase_ff == lzbf_pkg::PH_LIT || phase_ff == lzbf_pkg::PH_DBYTE
                || phase_ff == lzbf_pkg::PH_COPY || phase_ff == lzbf_pkg::PH_DONE) begin
               ctrl_in = lzbf_pkg::ST_SEND;
            end else if ((phase_ff == lzbf_pkg::PH_LB && acc_shift[15:0] != 16'd0)
                         || (phase_ff == lzbf_pkg::PH_XB && bit_now)) begin
               ctrl_in = lzbf_pkg::ST_CHECK;
            end
         end
         lzbf_pkg::ST_CHECK: ctrl_in = lzbf_pkg::ST_PARSE;
         lzbf_pkg::ST_READ: ctrl_in = lzbf_pkg::ST_WAIT;
         lzbf_pkg::ST_WAIT: ctrl_in = (copy_left_ff == 17'd0 || copy_left_ff == 17'd1)
                                      ? lzbf_pkg::ST_PARSE : lzbf_pkg::ST_SEND;
         lzbf_pkg::ST_SEND: if (rsp_fire) ctrl_in = lzbf_pkg::ST_IDLE;
         default: ctrl_in = lzbf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      write_pos_in = write_pos_ff;
      produced_in = produced_ff;
      bit_word_in = bit_word_ff;
      bits_left_in = bits_left_ff;
      low_half_in = low_half_ff;
      low_held_in = low_held_ff;
      acc_in = acc_ff;
      dist_in = dist_ff;
      copy_left_in = copy_left_ff;
      err_in = err_ff;
      done_in = done_ff;
      out_valid_in = out_valid_ff;
      out_byte_in = out_byte_ff;
      rd_addr_in = rd_addr_ff;
      wr_en = 1'b0;
      wr_data = req_tdata;
      unique case (ctrl_ff)
         lzbf_pkg::ST_IDLE: begin
            if (req_fire) begin
               out_valid_in = 1'b0;
               out_byte_in = 8'd0;
               if (err_ff == lzbf_pkg::StatusOk && !done_ff) begin
                  if (req_tuser == lzbf_pkg::CmdContinue) begin
                     if (phase_ff != lzbf_pkg::PH_COPY) begin
                        err_in = lzbf_pkg::StatusBadKind;
                     end else begin
                        rd_addr_in = (idx_wide >= (AddrWidth + 1)'(WINDOW_BYTES))
                                     ? '0 : idx_wide[AddrWidth-1:0];
                     end
                  end else if (phase_ff == lzbf_pkg::PH_COPY) begin
                     err_in = lzbf_pkg::StatusBadKind;
                  end else if (phase_ff == lzbf_pkg::PH_LIT) begin
                     out_valid_in = 1'b1;
                     out_byte_in = req_tdata;
                     wr_en = 1'b1;
                     phase_in = lzbf_pkg::PH_FLAG;
                  end else if (phase_ff == lzbf_pkg::PH_DBYTE) begin
                     dist_in = lzbf_pkg::DistWidth'({acc_ff - 16'd3, req_tdata}) + 24'd1;
                     acc_in = 16'd0;
                     phase_in = lzbf_pkg::PH_LA;
                  end else if (!low_held_ff) begin
                     low_half_in = req_tdata;
                     low_held_in = 1'b1;
                  end else begin
                     bit_word_in = {req_tdata, low_half_ff};
                     bits_left_in = 5'd16;
                     low_held_in = 1'b0;
                  end
               end
            end
         end
         lzbf_pkg::ST_PARSE: begin
            if (!(err_ff != lzbf_pkg::StatusOk || bits_left_ff == 5'd0
                  || phase_ff == lzbf_pkg::PH_LIT || phase_ff == lzbf_pkg::PH_DBYTE
                  || phase_ff == lzbf_pkg::PH_COPY || phase_ff == lzbf_pkg::PH_DONE)) begin
               bits_left_in = bits_left_ff - 5'd1;
               unique case (phase_ff)
                  lzbf_pkg::PH_FLAG: begin
                     if (bit_now) begin
                        phase_in = lzbf_pkg::PH_LIT;
                     end else begin
                        acc_in = 16'd1;
                        phase_in = lzbf_pkg::PH_DA;
                     end
                  end
                  lzbf_pkg::PH_DA: begin
                     acc_in = acc_shift[15:0];
                     phase_in = lzbf_pkg::PH_DB;
                  end
                  lzbf_pkg::PH_DB: begin
                     priority if (acc_ff == 16'd0) begin
                        done_in = 1'b1;
                        phase_in = lzbf_pkg::PH_DONE;
                     end else if (!bit_now) begin
                        phase_in = lzbf_pkg::PH_DA;
                     end else if (acc_ff >= 16'd3) begin
                        phase_in = lzbf_pkg::PH_DBYTE;
                     end else begin
                        acc_in = 16'd0;
                        phase_in = lzbf_pkg::PH_LA;
                     end
                  end
                  lzbf_pkg::PH_LA: begin
                     acc_in = {15'd0, bit_now};
                     phase_in = lzbf_pkg::PH_LB;
                  end
                  lzbf_pkg::PH_LB: begin
                     if (acc_shift[15:0] == 16'd0) begin
                        acc_in = 16'd1;
                        phase_in = lzbf_pkg::PH_XA;
                     end else begin
                        acc_in = acc_shift[15:0];
                     end
                  end
                  lzbf_pkg::PH_XA: begin
                     acc_in = acc_shift[15:0];
                     phase_in = lzbf_pkg::PH_XB;
                  end
                  lzbf_pkg::PH_XB: begin
                     if (!bit_now) begin
                        phase_in = lzbf_pkg::PH_XA;
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end
         end
         lzbf_pkg::ST_CHECK: begin
            if (32'(dist_ff) > 32'(produced_ff) || dist_ff == '0) begin
               err_in = lzbf_pkg::StatusBadDistance;
            end else begin
               copy_left_in = len_calc;
               phase_in = lzbf_pkg::PH_COPY;
            end
         end
         lzbf_pkg::ST_READ: begin
         end
         lzbf_pkg::ST_WAIT: begin
            out_valid_in = 1'b1;
            out_byte_in = rd_data_ff;
            wr_en = 1'b1;
            wr_data = rd_data_ff;
            if (copy_left_ff == 17'd0 || copy_left_ff == 17'd1) begin
               copy_left_in = '0;
               phase_in = lzbf_pkg::PH_FLAG;
            end else begin
               copy_left_in = copy_left_ff - 17'd1;
            end
         end
         lzbf_pkg::ST_SEND: begin
         end
         default: begin
         end
      endcase
      if (wr_en) begin
         write_pos_in = (32'(write_pos_ff) + 1 >= WINDOW_BYTES) ? '0 : write_pos_ff + 1'b1;
         if (32'(produced_ff) < WINDOW_BYTES) produced_in = produced_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) history[write_pos_ff] <= wr_data;
      rd_data_ff <= history[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= lzbf_pkg::ST_IDLE;
         phase_ff <= lzbf_pkg::PH_FLAG;
         write_pos_ff <= '0;
         produced_ff <= '0;
         bit_word_ff <= '0;
         bits_left_ff <= '0;
         low_half_ff <= '0;
         low_held_ff <= 1'b0;
         acc_ff <= '0;
         dist_ff <= lzbf_pkg::DistWidth'(1);
         copy_left_ff <= '0;
         err_ff <= lzbf_pkg::StatusOk;
         done_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ctrl_ff <= ctrl_in;
         phase_ff <= phase_in;
         write_pos_ff <= write_pos_in;
         produced_ff <= produced_in;
         bit_word_ff <= bit_word_in;
         bits_left_ff <= bits_left_in;
         low_half_ff <= low_half_in;
         low_held_ff <= low_held_in;
         acc_ff <= acc_in;
         dist_ff <= dist_in;
         copy_left_ff <= copy_left_in;
         err_ff <= err_in;
         done_ff <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      rd_addr_ff <= rd_addr_in;
   end

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != lzbf_pkg::StatusOk) |=> (err_ff == $past(err_ff)))
      else $error("error code changed after being set");
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("finished flag dropped");
   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= 5'd16)
      else $error("flag bit count out of range");
   a_produced_sat: assert property (@(posedge clock) disable iff (reset)
      32'(produced_ff) <= WINDOW_BYTES)
      else $error("produced count beyond window");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;

   localparam int Window = lzbf_pkg::WindowBytesDefault;
   localparam int IdleLimit = 5000;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       copy_pending;
      logic       finished;
      logic [1:0] status;
   } result_type;

   class decomp_scoreboard;
      logic [7:0]  hist [Window];
      int unsigned wpos, produced, word, bits_left, low_half, acc, last_dist, copy_left;
      bit          low_held, done;
      logic [1:0]  err;
      lzbf_pkg::phase_type phase;
      result_type  pending_results [$];
      int          mismatches;

      function new();
         wpos = 0; produced = 0; word = 0; bits_left = 0; low_half = 0; low_held = 0;
         acc = 0; last_dist = 1; copy_left = 0; err = lzbf_pkg::StatusOk; done = 0;
         phase = lzbf_pkg::PH_FLAG; mismatches = 0;
      endfunction

      function void put(logic [7:0] b);
         hist[wpos] = b;
         wpos = (wpos + 1 >= Window) ? 0 : wpos + 1;
         if (produced < Window) produced++;
      endfunction

      function void start_copy();
         int unsigned len;
         len = acc + 1;
         if (last_dist > lzbf_pkg::LongDistance) len++;
         if (last_dist > produced || last_dist == 0) begin
            err = lzbf_pkg::StatusBadDistance;
            return;
         end
         copy_left = len & 'h1ffff;
         phase = lzbf_pkg::PH_COPY;
      endfunction

      function void parse();
         bit b;
         while (err == lzbf_pkg::StatusOk) begin
            if (phase inside {lzbf_pkg::PH_LIT, lzbf_pkg::PH_DBYTE, lzbf_pkg::PH_COPY,
                              lzbf_pkg::PH_DONE} || bits_left == 0) return;
            bits_left--;
            b = (word >> bits_left) & 1;
            case (phase)
               lzbf_pkg::PH_FLAG: begin
                  if (b) phase = lzbf_pkg::PH_LIT;
                  else begin
                     acc = 1;
                     phase = lzbf_pkg::PH_DA;
                  end
               end
               lzbf_pkg::PH_DA: begin
                  acc = ((acc << 1) | b) & 'hffff;
                  phase = lzbf_pkg::PH_DB;
               end
               lzbf_pkg::PH_DB: begin
                  if (acc == 0) begin
                     done = 1;
                     phase = lzbf_pkg::PH_DONE;
                  end else if (!b) phase = lzbf_pkg::PH_DA;
                  else if (acc >= 3) phase = lzbf_pkg::PH_DBYTE;
                  else begin
                     acc = 0;
                     phase = lzbf_pkg::PH_LA;
                  end
               end
               lzbf_pkg::PH_LA: begin
                  acc = b;
                  phase = lzbf_pkg::PH_LB;
               end
               lzbf_pkg::PH_LB: begin
                  acc = (acc << 1) | b;
                  if (acc == 0) begin
                     acc = 1;
                     phase = lzbf_pkg::PH_XA;
                  end else start_copy();
               end
               lzbf_pkg::PH_XA: begin
                  acc = ((acc << 1) | b) & 'hffff;
                  phase = lzbf_pkg::PH_XB;
               end
               default: begin
                  if (b) begin
                     acc += 2;
                     start_copy();
                  end else phase = lzbf_pkg::PH_XA;
               end
            endcase
         end
      endfunction

      function void note_item(logic cmd, logic [7:0] data);
         result_type r;
         int unsigned src;
         r = '0;
         if (err == lzbf_pkg::StatusOk && !done) begin
            if (cmd == lzbf_pkg::CmdContinue) begin
               if (phase != lzbf_pkg::PH_COPY) err = lzbf_pkg::StatusBadKind;
               else begin
                  src = (wpos >= last_dist) ? wpos - last_dist : wpos + Window - last_dist;
                  if (src >= Window) src = 0;
                  r.out_byte = hist[src];
                  r.out_valid = 1;
                  put(r.out_byte);
                  if (copy_left > 0) copy_left--;
                  if (copy_left == 0) begin
                     phase = lzbf_pkg::PH_FLAG;
                     parse();
                  end
               end
            end else if (phase == lzbf_pkg::PH_COPY) err = lzbf_pkg::StatusBadKind;
            else if (phase == lzbf_pkg::PH_LIT) begin
               r.out_byte = data;
               r.out_valid = 1;
               put(data);
               phase = lzbf_pkg::PH_FLAG;
               parse();
            end else if (phase == lzbf_pkg::PH_DBYTE) begin
               last_dist = ((((acc - 3) & 'hffff) << 8) | data) + 1;
               acc = 0;
               phase = lzbf_pkg::PH_LA;
               parse();
            end else if (!low_held) begin
               low_half = data;
               low_held = 1;
            end else begin
               word = (data << 8) | low_half;
               bits_left = 16;
               low_held = 0;
               parse();
            end
         end
         r.copy_pending = (err == lzbf_pkg::StatusOk && phase == lzbf_pkg::PH_COPY);
         r.finished = done;
         r.status = err;
         pending_results.push_back(r);
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         $display("tb: mismatch on %s: got %0h, expected %0h", what, got, want);
         mismatches++;
      endtask

      task check_result(logic tuser, logic [15:0] tdata);
         result_type e;
         if (pending_results.size() == 0) begin
            report("unexpected result", tdata, 0);
            return;
         end
         e = pending_results.pop_front();
         if (tuser !== e.out_valid) report("out_valid", tuser, e.out_valid);
         if (tdata[7:0] !== e.out_byte) report("out_byte", tdata[7:0], e.out_byte);
         if (tdata[8] !== e.copy_pending) report("copy_pending", tdata[8], e.copy_pending);
         if (tdata[9] !== e.finished) report("finished", tdata[9], e.finished);
         if (tdata[11:10] !== e.status) report("status", tdata[11:10], e.status);
         if (tdata[15:12] !== 4'd0) report("zero fill", tdata[15:12], 0);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;

   decomp_scoreboard sb = new();
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  idle_cycles = 0;
   int  items_sent = 0;
   int  literals_sent = 0;
   bit  literal_planned = 0;
   bit  flags_plan [$];
   logic [15:0] cur_word;

   lz_bitflag_decompressor DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task push_item(logic cmd, logic [7:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      sb.note_item(cmd, data);
      items_sent++;
      case ((items_sent / 300) % 4)
         0: begin send_idle_pct = 0; recv_stall_pct = 0; end
         1: begin send_idle_pct = 63; recv_stall_pct = 0; end
         2: begin send_idle_pct = 0; recv_stall_pct = 63; end
         default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
   endtask

   function void emit_gamma(int unsigned v);
      int msb;
      msb = 31;
      while (!v[msb]) msb--;
      for (int i = msb - 1; i >= 0; i--) begin
         flags_plan.push_back(v[i]);
         flags_plan.push_back(i == 0);
      end
   endfunction

   function void emit_match(int unsigned dist_code, int unsigned len_code);
      flags_plan.push_back(0);
      emit_gamma(dist_code);
      if (len_code <= 3) begin
         flags_plan.push_back(len_code[1]);
         flags_plan.push_back(len_code[0]);
      end else begin
         flags_plan.push_back(0);
         flags_plan.push_back(0);
         emit_gamma(len_code - 2);
      end
   endfunction

   function void plan_token();
      int unsigned bound, len_code, pick;
      bound = (sb.produced == 0) ? 1 : sb.produced;
      if (sb.produced == 0 && !literal_planned || $urandom_range(0, 99) < 45) begin
         flags_plan.push_back(1);
         literal_planned = 1;
         return;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) len_code = $urandom_range(1, 8);
      else if (pick < 96) len_code = $urandom_range(9, 40);
      else len_code = $urandom_range(41, 300);
      if ($urandom_range(0, 99) < 30) emit_match(2, len_code);
      else emit_match(3 + $urandom_range(0, (bound - 1) >> 8), len_code);
   endfunction

   task drive_next(bit noise_ok);
      int unsigned hi, maxb;
      if (sb.phase == lzbf_pkg::PH_COPY) push_item(lzbf_pkg::CmdContinue, 8'($urandom));
      else if (sb.phase == lzbf_pkg::PH_LIT) begin
         literals_sent++;
         push_item(lzbf_pkg::CmdByte, literals_sent == 1 ? 8'h00 :
                                      literals_sent == 2 ? 8'hff : 8'($urandom));
      end else if (sb.phase == lzbf_pkg::PH_DBYTE) begin
         hi = ((sb.acc - 3) & 'hffff) << 8;
         if (hi + 1 > sb.produced) push_item(lzbf_pkg::CmdByte, 8'hff);
         else begin
            maxb = sb.produced - 1 - hi;
            push_item(lzbf_pkg::CmdByte, 8'($urandom_range(0, maxb > 255 ? 255 : maxb)));
         end
      end else if (!sb.low_held) begin
         while (noise_ok && flags_plan.size() < 16) plan_token();
         while (flags_plan.size() < 16) flags_plan.push_back(0);
         for (int i = 15; i >= 0; i--) cur_word[i] = flags_plan.pop_front();
         push_item(lzbf_pkg::CmdByte, cur_word[7:0]);
      end else push_item(lzbf_pkg::CmdByte, cur_word[15:8]);
   endtask

   initial begin
      int ending;
      repeat (8) @(posedge clock);
      reset <= 0;
      while (items_sent < 1750) drive_next(1);
      ending = $urandom_range(0, 2);
      if (ending == 0) begin
         flags_plan.push_back(0);
         repeat (16) begin
            flags_plan.push_back(0);
            flags_plan.push_back(0);
         end
      end else if (ending == 1) begin
         emit_match(3 + (sb.produced >> 8) + 40, 1);
      end
      if (ending == 2) begin
         push_item(sb.phase == lzbf_pkg::PH_COPY ? lzbf_pkg::CmdByte : lzbf_pkg::CmdContinue,
                   8'($urandom));
      end
      while (sb.err == lzbf_pkg::StatusOk && !sb.done) drive_next(0);
      repeat (4) push_item(1'($urandom_range(0, 1)), 8'($urandom));
      req_tvalid <= 0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end
endmodule

[sim.f]
rtl/lzbf_pkg.sv
rtl/lz_bitflag_decompressor.sv
bench/tb.sv
